// File: hdl/ftdi_pkg.sv
// ftdi_pkg: shared types, widths, reset values and the quadrature step decoder
// for the furnace thermostat with door interlock; no dependencies
package ftdi_pkg;

    localparam int DELAY_W    = 12;
    localparam int HYST_W     = 8;
    localparam int STEP_W     = 6;
    localparam int ENC_W      = 2;
    localparam int TEMP_W     = 12;
    localparam int SP_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam int TIMER_BITS_DEF = 12;

    localparam logic [SP_W-1:0]    SETPOINT_MAX   = 10'd1023;
    localparam logic [SP_W-1:0]    SETPOINT_RESET = 10'd700;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 12'd2000;
    localparam logic [HYST_W-1:0]  HYST_RESET     = 8'd20;
    localparam logic [STEP_W-1:0]  STEP_RESET     = 6'd5;

    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_STEP    = 2'd2;

    typedef struct packed {
        logic [DELAY_W-1:0] close_delay;
        logic [HYST_W-1:0]  hysteresis;
        logic [STEP_W-1:0]  enc_step;
    } t_cfg;

    typedef struct packed {
        logic [SP_W-1:0] setpoint;
        logic            waiting;
        logic            safe;
        logic            coil;
    } t_stat;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } t_dir;

    // index is {previous pins, current pins}
    function automatic t_dir step_dir(input logic [2*ENC_W-1:0] idx);
        t_dir d;
        unique case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/ftdi_cfg.sv
// ftdi_cfg: configuration register file for the thermostat
// depends on ftdi_pkg
module ftdi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ftdi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ftdi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ftdi_pkg::t_cfg                   o_cfg
);

    ftdi_pkg::t_cfg r_cfg;
    logic           wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid & o_cfg_ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.close_delay <= ftdi_pkg::DELAY_RESET;
            r_cfg.hysteresis  <= ftdi_pkg::HYST_RESET;
            r_cfg.enc_step    <= ftdi_pkg::STEP_RESET;
        end else if (wr) begin
            unique case (i_cfg_index)
                ftdi_pkg::REG_CLOSE_DELAY: r_cfg.close_delay <= i_cfg_data;
                ftdi_pkg::REG_HYSTERESIS:
                    r_cfg.hysteresis <= i_cfg_data[ftdi_pkg::HYST_W-1:0];
                ftdi_pkg::REG_ENC_STEP:
                    r_cfg.enc_step <= i_cfg_data[ftdi_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/ftdi_core.sv
// ftdi_core: thermostat state and per-tick update (encoder, door timer, coil)
// depends on ftdi_pkg
module ftdi_core #(
    parameter int TIMER_BITS = ftdi_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_door,
    input  logic [ftdi_pkg::ENC_W-1:0]    i_ab,
    input  logic                          i_temp_valid,
    input  logic [ftdi_pkg::TEMP_W-1:0]   i_temp,
    input  ftdi_pkg::t_cfg                i_cfg,
    output ftdi_pkg::t_stat               o_stat
);

    localparam int CMP_W = (TIMER_BITS > ftdi_pkg::DELAY_W) ? TIMER_BITS : ftdi_pkg::DELAY_W;
    localparam int SP_W  = ftdi_pkg::SP_W;

    logic [SP_W-1:0]               r_sp, n_sp;
    logic [ftdi_pkg::ENC_W-1:0]    r_prev_enc;
    logic [ftdi_pkg::TEMP_W-1:0]   r_temp, n_temp;
    logic                          r_prev_door;
    logic [TIMER_BITS-1:0]         r_timer, n_timer;
    logic                          r_safe, n_safe;
    logic                          r_wait, n_wait;
    logic                          r_coil, n_coil;

    ftdi_pkg::t_dir                dir;
    logic [SP_W:0]                 sp_up;
    logic [SP_W+2:0]               hi_lim;

    always_comb begin
        dir   = ftdi_pkg::step_dir({r_prev_enc, i_ab});
        sp_up = {1'b0, r_sp} + (SP_W+1)'(i_cfg.enc_step);
        n_sp  = r_sp;
        case (dir)
            ftdi_pkg::DIR_UP:
                n_sp = (sp_up > (SP_W+1)'(ftdi_pkg::SETPOINT_MAX)) ?
                       ftdi_pkg::SETPOINT_MAX : sp_up[SP_W-1:0];
            ftdi_pkg::DIR_DOWN:
                n_sp = (r_sp < SP_W'(i_cfg.enc_step)) ? '0 : r_sp - SP_W'(i_cfg.enc_step);
            default: ;
        endcase

        n_temp = i_temp_valid ? i_temp : r_temp;

        n_timer = r_timer;
        n_safe  = r_safe;
        n_wait  = r_wait;
        n_coil  = r_coil;
        if (i_door != r_prev_door) begin
            if (!i_door) begin
                n_safe = 1'b0;
                n_coil = 1'b0;
            end else begin
                n_timer = '0;
            end
        end else if (!(&r_timer)) begin
            n_timer = r_timer + TIMER_BITS'(1);
        end

        if (i_door) begin
            if (CMP_W'(n_timer) >= CMP_W'(i_cfg.close_delay)) begin
                n_safe = 1'b1;
                n_wait = 1'b0;
            end else if (!n_safe) begin
                n_wait = 1'b1;
            end
        end else begin
            n_safe = 1'b0;
            n_wait = 1'b0;
        end

        // limits in quarter degrees
        hi_lim = {({1'b0, n_sp} + (SP_W+1)'(i_cfg.hysteresis)), 2'b00};
        if (n_temp <= {n_sp, 2'b00}) begin
            if (n_safe) begin
                n_coil = 1'b1;
            end
        end else if ({1'b0, n_temp} > hi_lim) begin
            n_coil = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= ftdi_pkg::SETPOINT_RESET;
            r_prev_enc  <= '0;
            r_temp      <= '0;
            r_prev_door <= 1'b0;
            r_timer     <= '0;
            r_safe      <= 1'b0;
            r_wait      <= 1'b1;
            r_coil      <= 1'b0;
        end else if (i_fire) begin
            r_sp        <= n_sp;
            r_prev_enc  <= i_ab;
            r_temp      <= n_temp;
            r_prev_door <= i_door;
            r_timer     <= n_timer;
            r_safe      <= n_safe;
            r_wait      <= n_wait;
            r_coil      <= n_coil;
        end
    end

    assign o_stat.setpoint = n_sp;
    assign o_stat.waiting  = n_wait;
    assign o_stat.safe     = n_safe;
    assign o_stat.coil     = n_coil;

    a_coil_needs_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coil |-> r_safe)
        else $error("coil on while door not safe");

    a_safe_wait_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_safe && r_wait))
        else $error("safe and waiting both set");

    a_open_door_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_door) |=> (!r_safe && !r_coil && !r_wait))
        else $error("open door left heating enabled");

    a_hold_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_sp) && $stable(r_timer)))
        else $error("state moved without a transfer");

endmodule

// File: hdl/furnace_thermostat_with_door_interlock_unit.sv
// furnace thermostat with door interlock: top level with input and result registers
// depends on ftdi_pkg, ftdi_cfg, ftdi_core
// the input register and then the result register lie between input transfer and the earliest
//   result transfer; the state update is one pass of logic between the registers
// throughput: 1 item per cycle while i_m_tready does not stall the result register
// reset: synchronous active-low i_rst_n clears both stages, config to defaults,
//   setpoint 700, door seen open, waiting flag set, coil off
module furnace_thermostat_with_door_interlock_unit #(
    parameter int TIMER_BITS = ftdi_pkg::TIMER_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // door_closed[0], encoder_ab[2:1], temp_valid[3], temp_quarter[15:4]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ftdi_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // coil_on[0], door_safe[1], door_waiting[2], setpoint_deg[12:3], zero[15:13]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ftdi_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ftdi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ftdi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ftdi_pkg::t_cfg                       cfg;
    ftdi_pkg::t_stat                      stat;
    logic                                 r_in_vld;
    logic [ftdi_pkg::IN_DATA_W-1:0]       r_in_data;
    logic                                 r_out_vld;
    ftdi_pkg::t_stat                      r_out;
    logic                                 fire;
    logic                                 in_xfer;

    assign fire       = r_in_vld & (~r_out_vld | i_m_tready);
    assign o_s_tready = ~r_in_vld | fire;
    assign in_xfer    = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_s_tdata;
        end
        if (fire) begin
            r_out <= stat;
        end
    end

    ftdi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ftdi_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_door       (r_in_data[0]),
        .i_ab         (r_in_data[2:1]),
        .i_temp_valid (r_in_data[3]),
        .i_temp       (r_in_data[15:4]),
        .i_cfg        (cfg),
        .o_stat       (stat)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out.setpoint, r_out.waiting, r_out.safe, r_out.coil};

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_vld && r_out_vld))
        else $error("input stalled with a free stage");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed item lost");

endmodule
